FILE: rtl/core/text_console_cell_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console cell writer assertion macros
// Shared helpers for the concurrent checks that guard the console core.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

`ifndef SYNTH

// Condition holds in the same cycle as the trigger.
`define TCCW_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("console core check failed");

// Condition holds in the cycle after the trigger.
`define TCCW_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("console core check failed");

`else

`define TCCW_ASSERT_NOW(label, clk, rst, trig, cond)
`define TCCW_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

FILE: rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Screen geometry, field widths, cell constants and command codes.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int LINES      = 25;
  localparam int CELL_COUNT = COLUMNS * LINES;
  localparam int COPY_LEN   = (LINES - 1) * COLUMNS;

  // Field widths fixed by the stream format.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 3;

  // Memory address and sweep counter widths.
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);

  // Character and cell constants.
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CELL_W-1:0] CELL_BLANK   = 16'h0720;
  localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'd7;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CHAR = 3'd0,
    CMD_PUT_CELL   = 3'd1,
    CMD_SET_CURSOR = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_READ_CELL  = 3'd4
  } cmd_t;

endpackage

FILE: rtl/core/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// Keeps a screen of character/attribute cells in a single-port-write memory
// and a cursor; a small sequencer walks the memory for scroll and clear.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes the execute and done states to the result
// register; a cell read adds a read-wait state. Scroll: a copy pass moves rows up,
// then a fill pass blanks the bottom row. Clear: a fill pass writes every cell.
// Throughput: one word at a time; the input is not ready while a word runs.
// Reset: a clearing pass writes blank cells to the whole screen;
// no input word is taken until it ends, configuration writes are taken.
`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: text color.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Command input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], cell_attr[15:8], col[22:16], row[27:23]
  input  logic [2:0]  s_tuser,   // command[2:0]
  // Result output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // cursor_col[6:0], cursor_row[11:7],
                                 // cursor_offset[22:12], read_data[38:23]
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [BYTE_W-1:0]   text_color;
  logic [BYTE_W-1:0]   fill_char;
  logic [BYTE_W-1:0]   fill_attr;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_line;
  logic [CELL_W-1:0]   rd;

  // Latched command word.
  cmd_t                cmd_q;
  logic [BYTE_W-1:0]   ch_q;
  logic [BYTE_W-1:0]   attr_q;
  logic [COL_W-1:0]    x_q;
  logic [ROW_W-1:0]    y_q;

  // Result register.
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [OFF_W-1:0]    out_off;
  logic [CELL_W-1:0]   out_rd;

  // Screen memory.
  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  // Command decode results.
  logic                in_range;
  logic [COL_W-1:0]    ex_col;
  logic [ROW_W-1:0]    ex_line;
  logic [COL_W-1:0]    pos_col;
  logic [ROW_W-1:0]    pos_row;
  logic [ADDR_W-1:0]   pos_addr;
  logic                ex_we;
  logic [CELL_W-1:0]   ex_wdata;
  logic                ex_re;
  logic                ex_scroll;
  logic                ex_clear;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tdata   = {1'b0, out_rd, out_off, out_row, out_col};

  // Decode the latched command into a cursor update and at most one memory access.
  always_comb begin
    in_range  = ({1'b0, x_q} < (COL_W + 1)'(COLUMNS)) &&
                ({1'b0, y_q} < (ROW_W + 1)'(LINES));
    ex_col    = cur_col;
    ex_line   = cur_line;
    pos_col   = cur_col;
    pos_row   = cur_line;
    ex_we     = 1'b0;
    ex_wdata  = {text_color, ch_q};
    ex_re     = 1'b0;
    ex_scroll = 1'b0;
    ex_clear  = 1'b0;
    unique case (cmd_q)
      CMD_WRITE_CHAR: begin
        if (ch_q == CH_NEWLINE) begin
          ex_col = '0;
          if (cur_line == ROW_W'(LINES - 1)) begin
            ex_scroll = 1'b1;
          end else begin
            ex_line = cur_line + 1'b1;
          end
        end else if (ch_q == CH_BACKSPACE) begin
          // Step back, wrapping to the previous row end; the origin holds.
          if (cur_col != '0) begin
            ex_col = cur_col - 1'b1;
          end else if (cur_line != '0) begin
            ex_line = cur_line - 1'b1;
            ex_col  = COL_W'(COLUMNS - 1);
          end
          pos_col  = ex_col;
          pos_row  = ex_line;
          ex_we    = 1'b1;
          ex_wdata = {text_color, CH_SPACE};
        end else begin
          ex_we = 1'b1;
          if (cur_col == COL_W'(COLUMNS - 1)) begin
            ex_col = '0;
            if (cur_line == ROW_W'(LINES - 1)) begin
              ex_scroll = 1'b1;
            end else begin
              ex_line = cur_line + 1'b1;
            end
          end else begin
            ex_col = cur_col + 1'b1;
          end
        end
      end
      CMD_PUT_CELL: begin
        pos_col  = x_q;
        pos_row  = y_q;
        ex_we    = in_range;
        ex_wdata = {attr_q, ch_q};
      end
      CMD_SET_CURSOR: begin
        if (in_range) begin
          ex_col  = x_q;
          ex_line = y_q;
        end
      end
      CMD_CLEAR: begin
        ex_clear = 1'b1;
        ex_col   = '0;
        ex_line  = '0;
      end
      CMD_READ_CELL: begin
        pos_col = x_q;
        pos_row = y_q;
        ex_re   = in_range;
      end
      default: begin
      end
    endcase
    pos_addr = cell_addr(pos_row, pos_col);
  end

  // Memory port control for each sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[ADDR_W-1:0];
    mem_wdata = {fill_attr, fill_char};
    mem_re    = 1'b0;
    mem_raddr = pos_addr;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_BLANK;
      end
      ST_EXEC: begin
        mem_we    = ex_we;
        mem_waddr = pos_addr;
        mem_wdata = ex_wdata;
        mem_re    = ex_re;
      end
      ST_COPY: begin
        // Read one row ahead, write the word read in the previous cycle.
        mem_re    = (cnt < CNT_W'(COPY_LEN));
        mem_raddr = cnt[ADDR_W-1:0] + ADDR_W'(COLUMNS);
        mem_we    = (cnt != '0);
        mem_waddr = cnt[ADDR_W-1:0] - 1'b1;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Screen memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  // Sequencer, cursor and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      cur_col  <= '0;
      cur_line <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The done state decides the result valid itself.
      if (m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          if (cnt == CNT_W'(CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q  <= cmd_t'(s_tuser);
            ch_q   <= s_tdata[7:0];
            attr_q <= s_tdata[15:8];
            x_q    <= s_tdata[22:16];
            y_q    <= s_tdata[27:23];
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cur_col   <= ex_col;
          cur_line  <= ex_line;
          rd        <= '0;
          fill_char <= CH_SPACE;
          fill_attr <= text_color;
          cnt       <= '0;
          if (ex_scroll) begin
            state <= ST_COPY;
          end else if (ex_clear) begin
            state <= ST_FILL;
          end else if (ex_re) begin
            state <= ST_READ_WAIT;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_READ_WAIT: begin
          rd    <= mem_rdata;
          state <= ST_DONE;
        end
        ST_COPY: begin
          // The fill of the bottom row starts where the copy ends.
          if (cnt == CNT_W'(COPY_LEN)) begin
            state <= ST_FILL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FILL: begin
          if (cnt == CNT_W'(CELL_COUNT - 1)) begin
            state <= ST_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_col  <= cur_col;
            out_row  <= cur_line;
            out_off  <= OFF_W'(int'(cur_line) * COLUMNS + int'(cur_col));
            out_rd   <= rd;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and cursor.
  `TCCW_ASSERT_NOW(a_col_range, clk, rst, 1'b1, cur_col < COL_W'(COLUMNS))
  `TCCW_ASSERT_NOW(a_line_range, clk, rst, 1'b1, cur_line < ROW_W'(LINES))
  `TCCW_ASSERT_NOW(a_waddr_range, clk, rst, mem_we, mem_waddr < ADDR_W'(CELL_COUNT))
  `TCCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `TCCW_ASSERT_NEXT(a_done_publishes, clk, rst, (state == ST_DONE) && !m_tvalid, m_tvalid)

endmodule

FILE: dv/text_console_cell_writer_tb.sv
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Sends console commands over the input stream and checks every result word
// against a cycle-free model of the screen, cursor and text color that runs
// in the bench. Directed tests cover cell access, cursor motion, wrap and
// scroll, clear and the spare command codes. Random traffic, a long output
// hold-off and several text colors follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cell_writer_tb
  import tccw_pkg::*;
();

  // Command codes that the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;

  // One result word, split into its fields.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFF_W-1:0]  offset;
    logic [CELL_W-1:0] rdata;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // char_code, cell_attr, col, row
  logic [2:0]  s_tuser = '0;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // cursor_col, cursor_row, cursor_offset, read_data

  text_console_cell_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the console state.
  logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
  int                cursor_x;
  int                cursor_y;
  logic [BYTE_W-1:0] shadow_color;

  cursor_report_t pending_results [$];
  int unsigned    mismatch_count = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    stall_requests = 0;
  int unsigned    stall_grants = 0;
  bit             sender_gaps = 1'b1;

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void shadow_fill(logic [CELL_W-1:0] fill_value);
    for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = fill_value;
  endfunction

  // Move every row up one and blank the bottom row in the current color.
  function automatic void shadow_scroll();
    for (int i = 0; i < COPY_LEN; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
    for (int i = COPY_LEN; i < CELL_COUNT; i++) screen_shadow[i] = {shadow_color, CH_SPACE};
    cursor_y = LINES - 1;
  endfunction

  function automatic void shadow_line_feed();
    cursor_x = 0;
    cursor_y++;
    if (cursor_y >= LINES) shadow_scroll();
  endfunction

  // Apply one command to the bench state and return the result word it gives.
  function automatic cursor_report_t predict_command(logic [CMD_W-1:0] cmd,
                                                     logic [BYTE_W-1:0] ch,
                                                     logic [BYTE_W-1:0] attr,
                                                     logic [COL_W-1:0] col,
                                                     logic [ROW_W-1:0] row);
    cursor_report_t report;
    bit on_screen;
    logic [CELL_W-1:0] cell_read;
    on_screen = (int'(col) < COLUMNS) && (int'(row) < LINES);
    cell_read = '0;
    case (cmd)
      CMD_WRITE_CHAR: begin
        if (ch == CH_NEWLINE) begin
          shadow_line_feed();
        end else if (ch == CH_BACKSPACE) begin
          // Step back, wrapping to the previous row; the origin holds.
          if (cursor_x > 0) begin
            cursor_x--;
          end else if (cursor_y > 0) begin
            cursor_y--;
            cursor_x = COLUMNS - 1;
          end
          screen_shadow[cursor_y * COLUMNS + cursor_x] = {shadow_color, CH_SPACE};
        end else begin
          screen_shadow[cursor_y * COLUMNS + cursor_x] = {shadow_color, ch};
          cursor_x++;
          if (cursor_x >= COLUMNS) shadow_line_feed();
        end
      end
      CMD_PUT_CELL: begin
        if (on_screen) screen_shadow[int'(row) * COLUMNS + int'(col)] = {attr, ch};
      end
      CMD_SET_CURSOR: begin
        if (on_screen) begin
          cursor_x = int'(col);
          cursor_y = int'(row);
        end
      end
      CMD_CLEAR: begin
        shadow_fill({shadow_color, CH_SPACE});
        cursor_x = 0;
        cursor_y = 0;
      end
      CMD_READ_CELL: begin
        if (on_screen) cell_read = screen_shadow[int'(row) * COLUMNS + int'(col)];
      end
      default: ;
    endcase
    report.col    = COL_W'(cursor_x);
    report.row    = ROW_W'(cursor_y);
    report.offset = OFF_W'(cursor_y * COLUMNS + cursor_x);
    report.rdata  = cell_read;
    return report;
  endfunction

  // Offer one command word and record its expected result once accepted.
  // The valid line stays high afterwards so back-to-back words need no toggle.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] ch,
                              logic [BYTE_W-1:0] attr, logic [COL_W-1:0] col,
                              logic [ROW_W-1:0] row);
    int unsigned gap;
    gap = sender_gaps ? gap_cycles() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, row, col, attr, ch};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_command(cmd, ch, attr, col, row));
  endtask

  // Drop the input and wait until every expected word has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_color(logic [BYTE_W-1:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_color = color;
  endtask

  // Reads and puts at the corners, out-of-range positions ignored.
  task automatic test_cell_access();
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_command(CMD_PUT_CELL, 8'hFF, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(LINES - 1));
    send_command(CMD_READ_CELL, 8'h00, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(LINES - 1));
    send_command(CMD_PUT_CELL, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_command(CMD_READ_CELL, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, ROW_W'(LINES));
    send_command(CMD_PUT_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
  endtask

  // Cursor placement, backspace at the origin and at the start of a row.
  task automatic test_cursor_moves();
    send_command(CMD_SET_CURSOR, 8'h00, 8'h00, COL_W'(COLUMNS), 5'd0);
    send_command(CMD_SET_CURSOR, 8'h00, 8'h00, 7'd0, 5'h1F);
    send_command(CMD_WRITE_CHAR, CH_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0);
    send_command(CMD_WRITE_CHAR, 8'h41, 8'h00, 7'd0, 5'd0);
    send_command(CMD_SET_CURSOR, 8'h00, 8'h00, 7'd0, 5'd1);
    send_command(CMD_WRITE_CHAR, CH_BACKSPACE, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, COL_W'(COLUMNS - 1), 5'd0);
  endtask

  // Wrap off the last cell and a newline on the bottom row both scroll.
  task automatic test_scroll_wrap();
    send_command(CMD_SET_CURSOR, 8'h00, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(LINES - 1));
    send_command(CMD_WRITE_CHAR, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(LINES - 2));
    send_command(CMD_WRITE_CHAR, CH_NEWLINE, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd0, ROW_W'(LINES - 1));
  endtask

  task automatic test_clear_and_spare();
    send_command(CMD_SPARE_FIRST, 8'hFF, 8'hFF, 7'd3, 5'd3);
    send_command(CMD_SPARE_LAST, 8'h00, 8'h00, 7'h7F, 5'h1F);
    send_command(CMD_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ_CELL, 8'h00, 8'h00, 7'd40, 5'd12);
  endtask

  // Random command mix, leaning toward positions that reach written cells
  // and toward the bottom row so that scrolling happens often.
  task automatic test_random_traffic(int count);
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    int unsigned       pick;
    int unsigned       sel;
    put_col = '0;
    put_row = '0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      ch   = BYTE_W'($urandom_range(0, 255));
      attr = BYTE_W'($urandom_range(0, 255));
      col  = COL_W'($urandom_range(0, 127));
      row  = ROW_W'($urandom_range(0, 31));
      if (pick < 40) begin
        cmd = CMD_WRITE_CHAR;
        if (sel < 12) ch = CH_NEWLINE;
        else if (sel < 22) ch = CH_BACKSPACE;
      end else if (pick < 60) begin
        cmd = CMD_PUT_CELL;
        if (sel < 85) begin
          col = COL_W'($urandom_range(0, COLUMNS - 1));
          row = ROW_W'($urandom_range(0, LINES - 1));
        end
        put_col = col;
        put_row = row;
      end else if (pick < 70) begin
        cmd = CMD_SET_CURSOR;
        if (sel < 30) begin
          col = COL_W'($urandom_range(0, COLUMNS - 1));
          row = ROW_W'(LINES - 1);
        end else if (sel < 70) begin
          col = COL_W'($urandom_range(0, COLUMNS - 1));
          row = ROW_W'($urandom_range(0, LINES - 1));
        end
      end else if (pick < 73) begin
        cmd = CMD_CLEAR;
      end else if (pick < 98) begin
        cmd = CMD_READ_CELL;
        if (sel < 40) begin
          // The cell just written before the cursor.
          if (cursor_x > 0) begin
            col = COL_W'(cursor_x - 1);
            row = ROW_W'(cursor_y);
          end else if (cursor_y > 0) begin
            col = COL_W'(COLUMNS - 1);
            row = ROW_W'(cursor_y - 1);
          end else begin
            col = '0;
            row = '0;
          end
        end else if (sel < 70) begin
          col = put_col;
          row = put_row;
        end
      end else begin
        cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      send_command(cmd, ch, attr, col, row);
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_output_hold_off();
    sender_gaps = 1'b0;
    stall_requests++;
    wait (stall_grants == stall_requests);
    for (int n = 0; n < 12; n++) begin
      send_command((n % 2 == 0) ? CMD_PUT_CELL : CMD_READ_CELL,
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                   COL_W'($urandom_range(0, COLUMNS - 1)),
                   ROW_W'($urandom_range(0, LINES - 1)));
    end
    sender_gaps = 1'b1;
  endtask

  // Result ready: random runs high and low, plus requested long hold-offs.
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (stall_grants != stall_requests) begin
        m_tready <= 1'b0;
        hold = HOLD_OFF_CYCLES;
        stall_grants++;
      end else if ($urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        hold = $urandom_range(1, 40);
      end else begin
        m_tready <= 1'b0;
        hold = 1 + gap_cycles();
      end
      repeat (hold - 1) @(posedge clk);
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.col    = m_tdata[6:0];
      got.row    = m_tdata[11:7];
      got.offset = m_tdata[22:12];
      got.rdata  = m_tdata[38:23];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: col %0d row %0d offset %0d data %h",
                   got.col, got.row, got.offset, got.rdata);
      end else begin
        want = pending_results.pop_front();
        if (got.col !== want.col || got.row !== want.row ||
            got.offset !== want.offset || got.rdata !== want.rdata) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: want %0d,%0d off %0d data %h; got %0d,%0d off %0d data %h",
                     want.col, want.row, want.offset, want.rdata,
                     got.col, got.row, got.offset, got.rdata);
        end
      end
    end
  end

  // Count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Test sequence.
  initial begin
    shadow_fill(CELL_BLANK);
    shadow_color = COLOR_RESET;
    cursor_x = 0;
    cursor_y = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cell_access();
    settle();
    write_text_color(8'hFF);
    test_cursor_moves();
    test_scroll_wrap();
    settle();
    write_text_color(8'h00);
    test_clear_and_spare();
    settle();
    write_text_color(BYTE_W'($urandom_range(0, 255)));
    test_random_traffic(140);
    settle();
    write_text_color(8'hFF);
    test_random_traffic(140);
    settle();
    write_text_color(BYTE_W'($urandom_range(0, 255)));
    test_output_hold_off();
    test_random_traffic(140);
    settle();
    write_text_color(8'h00);
    test_random_traffic(140);
    settle();

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
